>>> hdl/hfc_pkg.sv
`timescale 1ns / 1ps

package hfc_pkg;

  localparam int unsigned KeyW       = 44;
  localparam int unsigned SlotFieldW = 10;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned DigitCnt   = KeyW / DigitW;
  localparam int unsigned DigitIdxW  = $clog2(DigitCnt);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_HINT_RD,
    ST_TAG_RD,
    ST_HINT_CHK,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } hfc_state_t;

  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic                  by_hint;
    logic [SlotFieldW-1:0] slot;
  } hfc_done_t;

endpackage

>>> hdl/hfc_if.sv
`timescale 1ns / 1ps

interface hfc_lookup_if;
  logic                      valid;
  logic                      ready;
  logic [hfc_pkg::KeyW-1:0]  isbn_value;

  modport source (output valid, output isbn_value, input ready);
  modport sink (input valid, input isbn_value, output ready);
endinterface

interface hfc_result_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [hfc_pkg::SlotFieldW-1:0]  slot;
  logic                            by_hint;

  modport source (output valid, output hit, output slot, output by_hint, input ready);
  modport sink (input valid, input hit, input slot, input by_hint, output ready);
endinterface

>>> hdl/hfc_ram.sv
`timescale 1ns / 1ps

module hfc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/hfc_seq.sv
`timescale 1ns / 1ps

module hfc_seq #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  hfc_lookup_if.sink                lookup,
  input  logic                      out_free,
  output hfc_pkg::hfc_done_t        done,
  output logic                      tag_we,
  output logic                      tag_re,
  output logic [$clog2(SLOTS)-1:0]  tag_addr,
  output logic [hfc_pkg::KeyW-1:0]  tag_wdata,
  input  logic [hfc_pkg::KeyW-1:0]  tag_rdata,
  output logic                      hint_we,
  output logic                      hint_re,
  output logic [$clog2(SLOTS)-1:0]  hint_addr,
  output logic [$clog2(SLOTS)-1:0]  hint_wdata,
  input  logic [$clog2(SLOTS)-1:0]  hint_rdata
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = SW + 1;
  localparam int unsigned DigitVals = 1 << hfc_pkg::DigitW;
  localparam logic [CW-1:0] SlotsC = CW'(SLOTS);
  localparam logic [SW-1:0] LastSlot = SW'(SLOTS - 1);

  hfc_pkg::hfc_state_t state, state_next;

  logic [hfc_pkg::KeyW-1:0]      key;
  logic [hfc_pkg::KeyW-1:0]      shreg;
  logic [hfc_pkg::DigitIdxW-1:0] digit_cnt;
  logic [SW-1:0]                 rem;
  logic [SW-1:0]                 hint_slot;
  logic [CW-1:0]                 scan_addr;
  logic [SW-1:0]                 cmp_addr;
  logic                          cmp_pend;
  logic [CW-1:0]                 fill;
  logic [SW-1:0]                 ins_ptr;
  logic [SW-1:0]                 clr_cnt;
  logic                          res_hit;
  logic                          res_by_hint;
  logic [SW-1:0]                 res_slot;

  logic [SW-1:0] digit_res [hfc_pkg::DigitCnt][DigitVals];
  logic [CW-1:0] res_sum;
  logic [SW-1:0] rem_step;
  logic          tag_match;
  logic          hint_ok;
  logic          scan_issue;
  logic          scan_match;

  // residue of each key digit at its position, constant per slot count
  for (genvar k = 0; k < hfc_pkg::DigitCnt; k++) begin : g_digit_pos
    for (genvar v = 0; v < DigitVals; v++) begin : g_digit_val
      assign digit_res[k][v] = SW'((64'(v) << (hfc_pkg::DigitW * k)) % 64'(SLOTS));
    end
  end

  // shared add and compare-subtract step of the key modulo, one digit a cycle
  assign res_sum  = {1'b0, rem}
                  + {1'b0, digit_res[digit_cnt][shreg[hfc_pkg::DigitW-1:0]]};
  assign rem_step = (res_sum >= SlotsC) ? SW'(res_sum - SlotsC) : res_sum[SW-1:0];

  assign tag_match  = (tag_rdata == key);
  assign hint_ok    = ({1'b0, hint_slot} < fill) && tag_match;
  assign scan_issue = (scan_addr < fill);
  assign scan_match = cmp_pend && tag_match;

  assign done.valid   = (state == hfc_pkg::ST_FINISH);
  assign done.hit     = res_hit;
  assign done.by_hint = res_by_hint;

  if (SW >= hfc_pkg::SlotFieldW) begin : g_slot_trunc
    assign done.slot = res_slot[hfc_pkg::SlotFieldW-1:0];
  end else begin : g_slot_ext
    assign done.slot = {{(hfc_pkg::SlotFieldW - SW){1'b0}}, res_slot};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hfc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    lookup.ready = 1'b0;
    tag_we       = 1'b0;
    tag_re       = 1'b0;
    tag_addr     = ins_ptr;
    tag_wdata    = key;
    hint_we      = 1'b0;
    hint_re      = 1'b0;
    hint_addr    = rem;
    hint_wdata   = ins_ptr;
    unique case (state)
      hfc_pkg::ST_CLEAR: begin
        hint_we    = 1'b1;
        hint_addr  = clr_cnt;
        hint_wdata = '0;
        if (clr_cnt == LastSlot) begin
          state_next = hfc_pkg::ST_IDLE;
        end
      end
      hfc_pkg::ST_IDLE: begin
        lookup.ready = 1'b1;
        if (lookup.valid) begin
          state_next = hfc_pkg::ST_MOD;
        end
      end
      hfc_pkg::ST_MOD: begin
        if (digit_cnt == hfc_pkg::DigitIdxW'(hfc_pkg::DigitCnt - 1)) begin
          state_next = hfc_pkg::ST_HINT_RD;
        end
      end
      hfc_pkg::ST_HINT_RD: begin
        hint_re    = 1'b1;
        state_next = hfc_pkg::ST_TAG_RD;
      end
      hfc_pkg::ST_TAG_RD: begin
        tag_re     = 1'b1;
        tag_addr   = hint_rdata;
        state_next = hfc_pkg::ST_HINT_CHK;
      end
      hfc_pkg::ST_HINT_CHK: begin
        state_next = hint_ok ? hfc_pkg::ST_FINISH : hfc_pkg::ST_SCAN;
      end
      hfc_pkg::ST_SCAN: begin
        tag_re   = scan_issue;
        tag_addr = scan_addr[SW-1:0];
        if (scan_match) begin
          state_next = hfc_pkg::ST_FINISH;
        end else if (!scan_issue) begin
          state_next = hfc_pkg::ST_WRITE;
        end
      end
      hfc_pkg::ST_WRITE: begin
        tag_we     = 1'b1;
        hint_we    = 1'b1;
        state_next = hfc_pkg::ST_FINISH;
      end
      hfc_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = hfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hfc_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      fill     <= '0;
      ins_ptr  <= '0;
      cmp_pend <= 1'b0;
    end else begin
      unique case (state)
        hfc_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
        end
        hfc_pkg::ST_IDLE: begin
          if (lookup.valid) begin
            key       <= lookup.isbn_value;
            shreg     <= lookup.isbn_value;
            digit_cnt <= '0;
            rem       <= '0;
          end
        end
        hfc_pkg::ST_MOD: begin
          rem       <= rem_step;
          shreg     <= shreg >> hfc_pkg::DigitW;
          digit_cnt <= digit_cnt + 1'b1;
        end
        hfc_pkg::ST_TAG_RD: begin
          hint_slot <= hint_rdata;
        end
        hfc_pkg::ST_HINT_CHK: begin
          scan_addr   <= '0;
          cmp_pend    <= 1'b0;
          res_hit     <= 1'b1;
          res_by_hint <= 1'b1;
          res_slot    <= hint_slot;
        end
        hfc_pkg::ST_SCAN: begin
          cmp_pend    <= scan_issue;
          cmp_addr    <= scan_addr[SW-1:0];
          res_hit     <= 1'b1;
          res_by_hint <= 1'b0;
          res_slot    <= cmp_addr;
          if (scan_issue) begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        hfc_pkg::ST_WRITE: begin
          res_hit     <= 1'b0;
          res_by_hint <= 1'b0;
          res_slot    <= ins_ptr;
          ins_ptr     <= (ins_ptr == LastSlot) ? '0 : ins_ptr + 1'b1;
          if (fill != SlotsC) begin
            fill <= fill + 1'b1;
          end
        end
        hfc_pkg::ST_FINISH: begin
          cmp_pend <= 1'b0;
        end
        default: begin
          cmp_pend <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> hdl/hashed_fifo_tag_cache_core.sv
`timescale 1ns / 1ps

// channel  | modport | payload
// lookup   | sink    | isbn_value[43:0]
// result   | source  | hit, slot[9:0], by_hint
//
// one lookup at a time; the key modulo adds one 4-bit digit residue a cycle over the 11 key digits
// hint hit: hint read, tag read and hint check follow the modulo, then back to idle if the result register is free
// miss or hint failure: the scan reads one tag a cycle over the filled slots
// after reset the hint table is cleared with lookup.ready low
// the result register lets a new beat in while the previous result waits

module hashed_fifo_tag_cache_core #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  hfc_lookup_if.sink   lookup,
  hfc_result_if.source result
);

  localparam int unsigned SW = $clog2(SLOTS);

  hfc_pkg::hfc_done_t        done;
  logic                      out_free;
  logic                      tag_we;
  logic                      tag_re;
  logic [SW-1:0]             tag_addr;
  logic [hfc_pkg::KeyW-1:0]  tag_wdata;
  logic [hfc_pkg::KeyW-1:0]  tag_rdata;
  logic                      hint_we;
  logic                      hint_re;
  logic [SW-1:0]             hint_addr;
  logic [SW-1:0]             hint_wdata;
  logic [SW-1:0]             hint_rdata;

  assign out_free = !result.valid || result.ready;

  hfc_seq #(
    .SLOTS(SLOTS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .lookup     (lookup),
    .out_free   (out_free),
    .done       (done),
    .tag_we     (tag_we),
    .tag_re     (tag_re),
    .tag_addr   (tag_addr),
    .tag_wdata  (tag_wdata),
    .tag_rdata  (tag_rdata),
    .hint_we    (hint_we),
    .hint_re    (hint_re),
    .hint_addr  (hint_addr),
    .hint_wdata (hint_wdata),
    .hint_rdata (hint_rdata)
  );

  hfc_ram #(
    .DEPTH(SLOTS),
    .WIDTH(hfc_pkg::KeyW)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .re    (tag_re),
    .addr  (tag_addr),
    .wdata (tag_wdata),
    .rdata (tag_rdata)
  );

  hfc_ram #(
    .DEPTH(SLOTS),
    .WIDTH(SW)
  ) u_hint_ram (
    .clk   (clk),
    .we    (hint_we),
    .re    (hint_re),
    .addr  (hint_addr),
    .wdata (hint_wdata),
    .rdata (hint_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (done.valid && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done.valid && out_free) begin
      result.hit     <= done.hit;
      result.slot    <= done.slot;
      result.by_hint <= done.by_hint;
    end
  end

endmodule

>>> hdl/hfc_checker.sv
`timescale 1ns / 1ps

module hfc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_hit,
  input logic [hfc_pkg::SlotFieldW-1:0]  out_slot,
  input logic                            out_by_hint
);

  logic [1:0] pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 2'd0)
    else $error("result beat without a lookup beat");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("lookup taken while busy");

  a_miss_not_hint: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_hit |-> !out_by_hint)
    else $error("miss flagged as hint hit");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_slot)
      && $stable(out_by_hint))
    else $error("stalled result changed");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("lookup ready during clear");

endmodule

bind hashed_fifo_tag_cache_core hfc_checker u_hfc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (lookup.valid),
  .in_ready    (lookup.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_hit     (result.hit),
  .out_slot    (result.slot),
  .out_by_hint (result.by_hint)
);
